// ----- rtl/vc_credit_link_channel_unit_macros.svh -----
// Assertion macros shared by the link channel RTL.
// Users must provide clk_i and rst_ni in the including scope.
`ifndef VC_CREDIT_LINK_CHANNEL_UNIT_MACROS_SVH
`define VC_CREDIT_LINK_CHANNEL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VCL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define VCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/vcl_pkg.sv -----
// Shared constants, codes and types of the virtual channel link.
// No dependencies; every other RTL module imports this package.
package vcl_pkg;

  localparam int NUM_VC      = 4;
  localparam int VC_W        = 2;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;
  localparam int DELAY_DEPTH = 8;
  localparam int DPTR_W      = 3;
  localparam int DCNT_W      = 4;
  localparam int TAG_W       = 16;
  localparam int XMIT_W      = 8;
  localparam int TIME_W      = 32;
  localparam int MEM_AW      = VC_W + QPTR_W;
  localparam int MEM_DEPTH   = NUM_VC * QUEUE_DEPTH;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ENQ  = 2'd1;
  localparam logic [1:0] FUNC_DEQ  = 2'd2;

  localparam logic [2:0] KIND_ENQ    = 3'd0;
  localparam logic [2:0] KIND_XFER   = 3'd1;
  localparam logic [2:0] KIND_DELIV  = 3'd2;
  localparam logic [2:0] KIND_DEQ    = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam logic [1:0] LS_IDLE = 2'd0;
  localparam logic [1:0] LS_WAIT = 2'd1;
  localparam logic [1:0] LS_XFER = 2'd2;

  localparam logic [1:0] CFG_LATENCY = 2'd0;
  localparam logic [1:0] CFG_DCRED   = 2'd1;
  localparam logic [1:0] CFG_SCRED   = 2'd2;
  localparam logic [1:0] CFG_LDIV    = 2'd3;

  typedef enum logic [1:0] {OP_TICK, OP_ENQ, OP_DEQ, OP_BAD} op_e;

  typedef struct packed {
    op_e               op;
    logic [VC_W-1:0]   vc;
    logic [TAG_W-1:0]  tag;
    logic [XMIT_W-1:0] xmit;
    logic              fast;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [VC_W-1:0]  vc;
    logic [TAG_W-1:0] tag;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [7:0] latency;
    logic [3:0] dcred;
    logic [3:0] scred;
    logic [3:0] ldiv;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        link;
    logic [XMIT_W-1:0] busy;
    logic [DCNT_W-1:0] dly_cnt;
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [XMIT_W-1:0] xmit;
    logic              fast;
  } src_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [VC_W-1:0]   vc;
    logic [TIME_W-1:0] due;
  } dly_entry_t;

endpackage

// ----- rtl/vcl_front.sv -----
// Front end: takes input beats, classifies them into commands and queues them.
// Depends on vcl_pkg.
module vcl_front import vcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // vc[1:0], msg_tag[17:2], transmit_latency[25:18], fast[26]
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.vc   = s_axis_tdata[1:0];
    cls.tag  = s_axis_tdata[17:2];
    cls.xmit = s_axis_tdata[25:18];
    cls.fast = s_axis_tdata[26];
    case (s_axis_tuser)
      FUNC_TICK: cls.op = OP_TICK;
      FUNC_ENQ:  cls.op = OP_ENQ;
      FUNC_DEQ:  cls.op = OP_DEQ;
      default:   cls.op = OP_BAD;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/vcl_div.sv -----
// Restoring divider for link occupancy: one quotient bit per cycle.
// Depends on vcl_pkg. A divisor of zero is treated as one.
module vcl_div import vcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [XMIT_W-1:0] dividend_i,
  input  logic [3:0]        divisor_i,
  output logic              done_o,
  output logic [XMIT_W-1:0] quot_o
);

  localparam logic [2:0] LAST_STEP = 3'(XMIT_W - 1);

  logic [XMIT_W-1:0] acc_q, acc_d;
  logic [3:0]        rem_q, rem_d, div_q, div_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              run_q, run_d, done_q, done_d;
  logic [4:0]        trial;

  assign trial = {rem_q, acc_q[XMIT_W-1]};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = dividend_i;
      rem_d = '0;
      div_d = (divisor_i == 4'd0) ? 4'd1 : divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 4'(trial - {1'b0, div_q});
        acc_d = {acc_q[XMIT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[3:0];
        acc_d = {acc_q[XMIT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

endmodule

// ----- rtl/vcl_back.sv -----
// Back end: executes queued commands against the FIFOs, link controller and delay line.
// Depends on vcl_pkg and vcl_div.
module vcl_back import vcl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    out_free_i,
  output logic    emit_o,
  output result_t res_o,
  output status_t status_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEQ   = 3'd1;
  localparam logic [2:0] ST_ARB   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] state_q, state_d;

  logic [QPTR_W-1:0] src_head_q [NUM_VC];
  logic [QPTR_W-1:0] src_head_d [NUM_VC];
  logic [QCNT_W-1:0] src_cnt_q  [NUM_VC];
  logic [QCNT_W-1:0] src_cnt_d  [NUM_VC];
  logic [QPTR_W-1:0] dst_head_q [NUM_VC];
  logic [QPTR_W-1:0] dst_head_d [NUM_VC];
  logic [QCNT_W-1:0] dst_cnt_q  [NUM_VC];
  logic [QCNT_W-1:0] dst_cnt_d  [NUM_VC];
  logic [QCNT_W-1:0] dst_used_q [NUM_VC];
  logic [QCNT_W-1:0] dst_used_d [NUM_VC];

  dly_entry_t        dly_q [DELAY_DEPTH];
  logic [DPTR_W-1:0] dly_head_q, dly_head_d;
  logic [DCNT_W-1:0] dly_cnt_q, dly_cnt_d;
  logic              dly_we;
  logic [DPTR_W-1:0] dly_waddr;
  dly_entry_t        dly_wdata;

  logic [1:0]        link_q, link_d;
  logic [XMIT_W-1:0] busy_q, busy_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [VC_W-1:0]   gvc_q, gvc_d, deq_vc_q, deq_vc_d;
  src_entry_t        sent_q, sent_d;
  logic              pend_valid_q, pend_valid_d;
  result_t           pend_q, pend_d;

  src_entry_t        src_mem [MEM_DEPTH];
  logic              src_we, src_re;
  logic [MEM_AW-1:0] src_waddr, src_raddr;
  src_entry_t        src_wdata, src_rdata_q;
  logic [TAG_W-1:0]  dst_mem [MEM_DEPTH];
  logic              dst_we, dst_re;
  logic [MEM_AW-1:0] dst_waddr, dst_raddr;
  logic [TAG_W-1:0]  dst_wdata, dst_rdata_q;

  logic              div_start, div_done;
  logic [XMIT_W-1:0] div_quot;

  logic              any_src, gfound, head_due;
  logic [VC_W-1:0]   gvc;
  dly_entry_t        hd;
  logic [TIME_W-1:0] age;

  vcl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (src_rdata_q.xmit),
    .divisor_i  (cfg_i.ldiv),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Lowest-numbered channel with a queued message, destination room and delay-line room wins.
  always_comb begin
    any_src = 1'b0;
    gfound  = 1'b0;
    gvc     = '0;
    for (int v = 0; v < NUM_VC; v++) begin
      if (src_cnt_q[v] != '0) begin
        any_src = 1'b1;
        if (!gfound && dst_used_q[v] < cfg_i.dcred &&
            dst_used_q[v] < QCNT_W'(QUEUE_DEPTH) &&
            dly_cnt_q < DCNT_W'(DELAY_DEPTH)) begin
          gfound = 1'b1;
          gvc    = VC_W'(v);
        end
      end
    end
  end

  // Due when the wrapped age is non-negative.
  assign hd       = dly_q[dly_head_q];
  assign age      = time_q - hd.due;
  assign head_due = (dly_cnt_q != '0) && !age[TIME_W-1];

  always_comb begin
    logic [1:0]        ls;
    logic [XMIT_W-1:0] bsy;
    logic [VC_W-1:0]   dv;
    state_d      = state_q;
    src_head_d   = src_head_q;
    src_cnt_d    = src_cnt_q;
    dst_head_d   = dst_head_q;
    dst_cnt_d    = dst_cnt_q;
    dst_used_d   = dst_used_q;
    dly_head_d   = dly_head_q;
    dly_cnt_d    = dly_cnt_q;
    link_d       = link_q;
    busy_d       = busy_q;
    time_d       = time_q;
    gvc_d        = gvc_q;
    deq_vc_d     = deq_vc_q;
    sent_d       = sent_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cmd_pop_o    = 1'b0;
    emit_o       = 1'b0;
    res_o        = '0;
    src_we       = 1'b0;
    src_waddr    = {cmd_i.vc, 3'(src_head_q[cmd_i.vc] + src_cnt_q[cmd_i.vc][QPTR_W-1:0])};
    src_wdata    = '{tag: cmd_i.tag, xmit: cmd_i.xmit, fast: cmd_i.fast};
    src_re       = 1'b0;
    src_raddr    = {gvc, src_head_q[gvc]};
    dst_re       = 1'b0;
    dst_raddr    = {cmd_i.vc, dst_head_q[cmd_i.vc]};
    dv           = hd.vc;
    dst_we       = 1'b0;
    dst_waddr    = {dv, 3'(dst_head_q[dv] + dst_cnt_q[dv][QPTR_W-1:0])};
    dst_wdata    = hd.tag;
    dly_we       = 1'b0;
    dly_waddr    = 3'(dly_head_q + dly_cnt_q[DPTR_W-1:0]);
    dly_wdata    = '{tag: sent_q.tag, vc: gvc_q,
                     due: time_q + (sent_q.fast ? TIME_W'(1) : TIME_W'(cfg_i.latency))};
    div_start    = 1'b0;
    ls           = link_q;
    bsy          = busy_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_ENQ: begin
              if (out_free_i) begin
                cmd_pop_o = 1'b1;
                emit_o    = 1'b1;
                res_o     = '{kind: KIND_REJECT, vc: cmd_i.vc, tag: cmd_i.tag, last: 1'b1};
                if (src_cnt_q[cmd_i.vc] < cfg_i.scred &&
                    src_cnt_q[cmd_i.vc] < QCNT_W'(QUEUE_DEPTH)) begin
                  src_we               = 1'b1;
                  src_cnt_d[cmd_i.vc]  = src_cnt_q[cmd_i.vc] + 1'b1;
                  res_o.kind           = KIND_ENQ;
                end
              end
            end
            OP_DEQ: begin
              if (dst_cnt_q[cmd_i.vc] != '0) begin
                cmd_pop_o = 1'b1;
                dst_re    = 1'b1;
                deq_vc_d  = cmd_i.vc;
                state_d   = ST_DEQ;
              end else if (out_free_i) begin
                cmd_pop_o = 1'b1;
                emit_o    = 1'b1;
                res_o     = '{kind: KIND_REJECT, vc: cmd_i.vc, tag: '0, last: 1'b1};
              end
            end
            OP_TICK: begin
              cmd_pop_o = 1'b1;
              state_d   = ST_ARB;
            end
            default: begin
              if (out_free_i) begin
                cmd_pop_o = 1'b1;
                emit_o    = 1'b1;
                res_o     = '{kind: KIND_REJECT, vc: cmd_i.vc, tag: '0, last: 1'b1};
              end
            end
          endcase
        end
      end
      ST_DEQ: begin
        if (out_free_i) begin
          emit_o               = 1'b1;
          res_o                = '{kind: KIND_DEQ, vc: deq_vc_q, tag: dst_rdata_q, last: 1'b1};
          dst_head_d[deq_vc_q] = dst_head_q[deq_vc_q] + 1'b1;
          dst_cnt_d[deq_vc_q]  = dst_cnt_q[deq_vc_q] - 1'b1;
          if (dst_used_q[deq_vc_q] != '0) begin
            dst_used_d[deq_vc_q] = dst_used_q[deq_vc_q] - 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_ARB: begin
        if (ls == LS_IDLE && any_src) begin
          ls = LS_WAIT;
        end
        if (ls == LS_WAIT && gfound) begin
          gvc_d   = gvc;
          src_re  = 1'b1;
          state_d = ST_RD;
        end else begin
          if (ls == LS_XFER) begin
            if (bsy != '0) begin
              bsy = bsy - 1'b1;
            end
            if (bsy == '0) begin
              ls = LS_IDLE;
            end
          end
          busy_d  = bsy;
          state_d = ST_DRAIN;
        end
        link_d = ls;
      end
      ST_RD: begin
        div_start = 1'b1;
        sent_d    = src_rdata_q;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          // Occupancy is at least one tick; this tick already counts.
          bsy    = (div_quot == '0) ? XMIT_W'(1) : div_quot;
          bsy    = bsy - 1'b1;
          busy_d = bsy;
          link_d = (bsy == '0) ? LS_IDLE : LS_XFER;
          dly_we = 1'b1;
          dly_cnt_d          = dly_cnt_q + 1'b1;
          src_head_d[gvc_q]  = src_head_q[gvc_q] + 1'b1;
          src_cnt_d[gvc_q]   = src_cnt_q[gvc_q] - 1'b1;
          dst_used_d[gvc_q]  = dst_used_q[gvc_q] + 1'b1;
          pend_valid_d       = 1'b1;
          pend_d             = '{kind: KIND_XFER, vc: gvc_q, tag: sent_q.tag, last: 1'b0};
          state_d            = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // One result is held back until we know whether another follows.
        // The delay line holds at most DELAY_DEPTH entries, so a tick delivers
        // at most DELAY_DEPTH messages.
        if (!pend_valid_q || out_free_i) begin
          if (pend_valid_q) begin
            emit_o     = 1'b1;
            res_o      = pend_q;
            res_o.last = !head_due;
          end
          if (head_due) begin
            dly_head_d = dly_head_q + 1'b1;
            dly_cnt_d  = dly_cnt_q - 1'b1;
            if (dst_cnt_q[dv] < QCNT_W'(QUEUE_DEPTH)) begin
              dst_we        = 1'b1;
              dst_cnt_d[dv] = dst_cnt_q[dv] + 1'b1;
            end
            pend_valid_d = 1'b1;
            pend_d       = '{kind: KIND_DELIV, vc: dv, tag: hd.tag, last: 1'b0};
          end else begin
            pend_valid_d = 1'b0;
            time_d       = time_q + 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign status_o = '{link: link_q, busy: busy_q, dly_cnt: dly_cnt_q};

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    if (src_re) begin
      src_rdata_q <= src_mem[src_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
    if (dst_re) begin
      dst_rdata_q <= dst_mem[dst_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_q[dly_waddr] <= dly_wdata;
    end
    gvc_q    <= gvc_d;
    deq_vc_q <= deq_vc_d;
    sent_q   <= sent_d;
    pend_q   <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int v = 0; v < NUM_VC; v++) begin
        src_head_q[v] <= '0;
        src_cnt_q[v]  <= '0;
        dst_head_q[v] <= '0;
        dst_cnt_q[v]  <= '0;
        dst_used_q[v] <= '0;
      end
      dly_head_q   <= '0;
      dly_cnt_q    <= '0;
      link_q       <= LS_IDLE;
      busy_q       <= '0;
      time_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      src_head_q   <= src_head_d;
      src_cnt_q    <= src_cnt_d;
      dst_head_q   <= dst_head_d;
      dst_cnt_q    <= dst_cnt_d;
      dst_used_q   <= dst_used_d;
      dly_head_q   <= dly_head_d;
      dly_cnt_q    <= dly_cnt_d;
      link_q       <= link_d;
      busy_q       <= busy_d;
      time_q       <= time_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule

// ----- rtl/vc_credit_link_channel_unit.sv -----
// Top level of the virtual channel link with credit flow control.
// Depends on vcl_pkg, vcl_front, vcl_back and the assertion macro header.
//
// Usage: each input beat is one command, selected by s_axis_tuser: a tick of
// the link, an enqueue of a message at the source, or a dequeue from a
// destination queue. Every command yields one or more result beats on the
// master side; m_axis_tuser gives the result kind and m_axis_tlast marks the
// final beat of a command. A tick that causes nothing yields no beat.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the block is idle. Enqueues and rejects are done in the back end after the
// two-entry command queue; a dequeue also waits for the registered destination
// memory read. A tick delivers each due message in turn; a tick that grants the
// link also waits for the source memory read and the bit-serial occupancy
// divider (eight steps and a registered done).
// Commands queue while the back end works, so the input side keeps taking
// beats until the queue fills. Reset empties all queues and the delay line,
// idles the link and zeroes the tick counter; registers return to their
// defaults. When the receiver stalls, the output register holds its beat and
// the back end waits; the command queue then backs up to s_axis_tready.
`include "vc_credit_link_channel_unit_macros.svh"

module vc_credit_link_channel_unit import vcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // vc[1:0], msg_tag[17:2], transmit_latency[25:18], fast_mode[26]
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_vc[1:0], out_tag[17:2]
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  cfg_t    cfg_q, cfg_d;
  logic    cmd_valid, cmd_pop, out_free, back_emit;
  cmd_t    cmd;
  result_t back_res, out_q;
  logic    out_valid_q, out_valid_d;
  status_t st;

  // Register writes take the low bits of the data word.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LATENCY: cfg_d.latency = cfg_wdata_i;
        CFG_DCRED:   cfg_d.dcred   = cfg_wdata_i[3:0];
        CFG_SCRED:   cfg_d.scred   = cfg_wdata_i[3:0];
        CFG_LDIV:    cfg_d.ldiv    = cfg_wdata_i[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  vcl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  vcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_free_i  (out_free),
    .emit_o      (back_emit),
    .res_o       (back_res),
    .status_o    (st)
  );

  // Output register: loads a new beat from the back end once the previous one is gone.
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = back_emit || (out_valid_q && !m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.tag, out_q.vc};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  always_ff @(posedge clk_i) begin
    if (back_emit) begin
      out_q <= back_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      cfg_q.latency <= 8'd1;
      cfg_q.dcred   <= 4'd8;
      cfg_q.scred   <= 4'd8;
      cfg_q.ldiv    <= 4'd1;
    end else begin
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  // A transferring link always has occupancy left to count down.
  `VCL_ASSERT_IMPL(a_xfer_busy, st.link == LS_XFER, st.busy != '0)
  // The back end never overwrites a beat that is still waiting.
  `VCL_ASSERT_IMPL(a_emit_free, back_emit, !out_valid_q || m_axis_tready)
  // The delay line never holds more than its depth.
  `VCL_ASSERT_IMPL(a_dly_bound, 1'b1, st.dly_cnt <= DCNT_W'(DELAY_DEPTH))
  // A stalled beat stays valid into the next cycle.
  `VCL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule
